// File: rtl/bsq_pkg.sv
// Shared types and constants for the bounded sorted priority queue.
package bsq_pkg;

   localparam int CMD_W     = 3;
   localparam int DIST_W    = 32;
   localparam int ITEM_W    = 31;
   localparam int SILO_W    = 16;
   localparam int CNT_W     = 7;
   localparam int CAP_W     = 7;
   localparam int CSR_AW    = 3;
   localparam int CSR_DW    = 32;
   localparam int DEPTH_DEF = 64;

   localparam logic [CAP_W-1:0] CAP_RESET  = 7'd64;
   localparam logic [CNT_W-1:0] FOUND_NONE = '1;

   typedef enum logic [CMD_W-1:0] {
      CMD_CLEAR     = 3'd0,
      CMD_INSERT    = 3'd1,
      CMD_POP       = 3'd2,
      CMD_FIND_ITEM = 3'd3,
      CMD_FIND_SILO = 3'd4
   } cmd_type;

   typedef enum logic {
      REG_CAPACITY = 1'b0
   } reg_type;

   typedef enum logic {
      ST_IDLE,
      ST_REPORT
   } state_type;

   typedef struct packed {
      logic [DIST_W-1:0] distance;
      logic [ITEM_W-1:0] item;
      logic [SILO_W-1:0] silo;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   typedef struct packed {
      logic      ins_en;
      logic      find_item;
      logic      find_silo;
      entry_type new_ent;
   } cell_ctl_type;

endpackage

// File: rtl/bsq_cell.sv
// One queue position: holds an entry, compares against the new beat, shifts from its neighbor.
module bsq_cell #(
   parameter int IDX = 0,
   parameter int CW  = 7
) (
   input  logic                 clock,
   input  bsq_pkg::cell_ctl_type ctl,
   input  logic [CW-1:0]        keep_cnt,
   input  logic [CW-1:0]        live_cnt,
   input  bsq_pkg::entry_type   left_ent,
   input  logic                 left_gt,
   output bsq_pkg::entry_type   ent,
   output logic                 gt,
   output logic                 live,
   output logic                 match_ff
);
   import bsq_pkg::*;

   localparam logic [CW-1:0] POS = CW'(IDX);

   entry_type ent_ff;
   entry_type ent_in;
   logic      match_in;

   assign ent  = ent_ff;
   assign live = POS < live_cnt;
   assign gt   = (ent_ff.distance > ctl.new_ent.distance) && (POS < keep_cnt);

   always_comb begin
      ent_in = ent_ff;
      if (ctl.ins_en && !gt) begin
         ent_in = left_gt ? ctl.new_ent : left_ent;
      end
      match_in = live && ((ctl.find_item && (ent_ff.item == ctl.new_ent.item)) ||
                          (ctl.find_silo && (ent_ff.silo == ctl.new_ent.silo)));
   end

   always_ff @(posedge clock) begin
      ent_ff   <= ent_in;
      match_ff <= match_in;
   end

endmodule

// File: rtl/bsq_pick.sv
// Binary tree that selects the highest flagged position with its index and payload.
module bsq_pick #(
   parameter int N = 64,
   parameter int W = 1
) (
   input  logic [N-1:0]         flag_i,
   input  logic [W-1:0]         data_i [N],
   output logic                 found_o,
   output logic [$clog2(N)-1:0] idx_o,
   output logic [W-1:0]         data_o
);
   localparam int L = $clog2(N);
   localparam int P = 1 << L;

   logic         f [L+1][P];
   logic [W-1:0] d [L+1][P];
   logic [L-1:0] x [L+1][P];

   for (genvar j = 0; j < P; j++) begin : g_leaf
      if (j < N) begin : g_used
         assign f[0][j] = flag_i[j];
         assign d[0][j] = data_i[j];
      end else begin : g_pad
         assign f[0][j] = 1'b0;
         assign d[0][j] = '0;
      end
      assign x[0][j] = L'(j);
   end

   for (genvar k = 0; k < L; k++) begin : g_lvl
      for (genvar j = 0; j < P; j++) begin : g_node
         if (j < (P >> (k + 1))) begin : g_used
            assign f[k+1][j] = f[k][2*j+1] | f[k][2*j];
            assign d[k+1][j] = f[k][2*j+1] ? d[k][2*j+1] : d[k][2*j];
            assign x[k+1][j] = f[k][2*j+1] ? x[k][2*j+1] : x[k][2*j];
         end else begin : g_pad
            assign f[k+1][j] = 1'b0;
            assign d[k+1][j] = '0;
            assign x[k+1][j] = '0;
         end
      end
   end

   assign found_o = f[L][0];
   assign idx_o   = x[L][0];
   assign data_o  = d[L][0];

endmodule

// File: rtl/bounded_sorted_priority_queue_core.sv
// Top level of the bounded sorted priority queue: cell row, pick trees, control and CSR.
//
// A command beat is taken at a rising edge where start is high and busy is low.
// Insert and both finds act on the row of cells at that edge; on insert every
// cell compares its distance with the new one and shifts from its neighbor in
// parallel, while clear and pop only change the occupancy. In the following
// cycle (busy high) two selection trees find the head entry and the last
// matching position; the status beat is driven on the rsp_ ports at the next
// edge with rsp_strobe high for exactly one cycle. A new command can be taken
// at the edge where that beat is taken, since the tree cycle holds busy high.
// The receiver cannot stall; each status beat must be taken in its cycle.
// The capacity register sits at CSR byte address 0 (reset 64); 0 acts as 1 and
// values above DEPTH act as DEPTH. Write it only while the queue is idle.
// Synchronous reset empties the queue and clears the strobe; entry storage is
// not cleared, since only positions below the occupancy are ever read.
module bounded_sorted_priority_queue_core #(
   parameter int DEPTH = bsq_pkg::DEPTH_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic [bsq_pkg::CMD_W-1:0]    req_cmd,
   input  logic [bsq_pkg::DIST_W-1:0]   req_new_dist,
   input  logic [bsq_pkg::ITEM_W-1:0]   req_item_id,
   input  logic [bsq_pkg::SILO_W-1:0]   req_silo_id,
   input  logic [bsq_pkg::CNT_W-1:0]    req_pop_count,
   output logic                         rsp_strobe,
   output logic                         rsp_head_valid,
   output logic [bsq_pkg::DIST_W-1:0]   rsp_head_dist,
   output logic [bsq_pkg::ITEM_W-1:0]   rsp_head_item,
   output logic [bsq_pkg::SILO_W-1:0]   rsp_head_silo,
   output logic [bsq_pkg::CNT_W-1:0]    rsp_occupancy,
   output logic signed [bsq_pkg::CNT_W-1:0] rsp_found_index,
   output logic                         rsp_inserted,
   output logic                         rsp_underflow,
   input  logic                         csr_psel,
   input  logic                         csr_penable,
   input  logic                         csr_pwrite,
   input  logic [bsq_pkg::CSR_AW-1:0]   csr_paddr,
   input  logic [bsq_pkg::CSR_DW-1:0]   csr_pwdata,
   output logic [bsq_pkg::CSR_DW-1:0]   csr_prdata,
   output logic                         csr_pready
);
   import bsq_pkg::*;

   localparam int CW = $clog2(DEPTH + 1);
   localparam int LW = $clog2(DEPTH);
   localparam int EW = (CW > CAP_W) ? CW : CAP_W;
   localparam logic [EW-1:0] DEPTH_E = EW'(DEPTH);
   localparam logic [EW-1:0] ONE_E   = EW'(1);

   state_type state_ff, state_in;
   logic [CW-1:0]    fill_ff, fill_in;
   logic [CAP_W-1:0] cap_ff;
   logic             ins_ff, under_ff;

   logic             acc;
   logic [EW-1:0]    cap_e, eff_cap, fill_e, cnt_e;
   logic             full, ins_ok;
   logic [CW-1:0]    keep_cnt;
   cell_ctl_type     ctl;

   entry_type        ent   [DEPTH];
   logic [ENTRY_W-1:0] ent_bits [DEPTH];
   logic [0:0]       dummy [DEPTH];
   logic [DEPTH-1:0] gt, live, match;

   logic             head_found, find_found;
   logic [LW-1:0]    find_idx;
   logic [ENTRY_W-1:0] head_bits;
   entry_type        head_ent;

   logic             reg_wr;

   // ---------------- control ----------------
   assign busy = (state_ff == ST_REPORT);
   assign acc  = start && !busy;

   assign cap_e   = EW'(cap_ff);
   assign eff_cap = (cap_e == '0) ? ONE_E : ((cap_e > DEPTH_E) ? DEPTH_E : cap_e);
   assign fill_e  = EW'(fill_ff);
   assign cnt_e   = EW'(req_pop_count);
   assign full    = fill_e >= eff_cap;
   assign ins_ok  = !full || (req_new_dist < rsp_head_dist);
   assign keep_cnt = full ? (fill_ff - CW'(1)) : fill_ff;

   always_comb begin
      ctl                   = '0;
      ctl.new_ent.distance  = req_new_dist;
      ctl.new_ent.item      = req_item_id;
      ctl.new_ent.silo      = req_silo_id;
      ctl.ins_en    = acc && (req_cmd == CMD_INSERT) && ins_ok;
      ctl.find_item = acc && (req_cmd == CMD_FIND_ITEM);
      ctl.find_silo = acc && (req_cmd == CMD_FIND_SILO);
   end

   always_comb begin
      state_in = state_ff;
      fill_in  = fill_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (acc) begin
               state_in = ST_REPORT;
               if (req_cmd == CMD_CLEAR) begin
                  fill_in = '0;
               end else if (ctl.ins_en) begin
                  fill_in = keep_cnt + CW'(1);
               end else if (req_cmd == CMD_POP) begin
                  fill_in = (cnt_e > fill_e) ? '0 : CW'(fill_e - cnt_e);
               end
            end
         end
         ST_REPORT: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         fill_ff  <= '0;
      end else begin
         state_ff <= state_in;
         fill_ff  <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (acc) begin
         ins_ff   <= ctl.ins_en;
         under_ff <= (req_cmd == CMD_POP) && (cnt_e > fill_e);
      end
   end

   // ---------------- cell row ----------------
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      entry_type left_ent;
      logic      left_gt;
      if (i == 0) begin : g_first
         assign left_ent = ctl.new_ent;
         assign left_gt  = 1'b0;
      end else begin : g_rest
         assign left_ent = ent[i-1];
         assign left_gt  = gt[i-1];
      end
      bsq_cell #(.IDX(i), .CW(CW)) u_cell (
         .clock    (clock),
         .ctl      (ctl),
         .keep_cnt (keep_cnt),
         .live_cnt (fill_ff),
         .left_ent (left_ent),
         .left_gt  (left_gt),
         .ent      (ent[i]),
         .gt       (gt[i]),
         .live     (live[i]),
         .match_ff (match[i])
      );
      assign ent_bits[i] = ent[i];
      assign dummy[i]    = 1'b0;
   end

   // ---------------- selection trees ----------------
   bsq_pick #(.N(DEPTH), .W(ENTRY_W)) u_head_pick (
      .flag_i  (live),
      .data_i  (ent_bits),
      .found_o (head_found),
      .idx_o   (),
      .data_o  (head_bits)
   );

   bsq_pick #(.N(DEPTH), .W(1)) u_find_pick (
      .flag_i  (match),
      .data_i  (dummy),
      .found_o (find_found),
      .idx_o   (find_idx),
      .data_o  ()
   );

   assign head_ent = head_bits;

   // ---------------- status beat ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe <= 1'b0;
      end else begin
         rsp_strobe <= (state_ff == ST_REPORT);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_head_dist <= '0;
      end else if (state_ff == ST_REPORT) begin
         rsp_head_dist <= head_found ? head_ent.distance : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_REPORT) begin
         rsp_head_valid  <= head_found;
         rsp_head_item   <= head_found ? head_ent.item : '0;
         rsp_head_silo   <= head_found ? head_ent.silo : '0;
         rsp_occupancy   <= CNT_W'(fill_ff);
         rsp_found_index <= find_found ? CNT_W'(find_idx) : FOUND_NONE;
         rsp_inserted    <= ins_ff;
         rsp_underflow   <= under_ff;
      end
   end

   // ---------------- CSR ----------------
   assign csr_pready = 1'b1;
   assign reg_wr = csr_psel && csr_penable && csr_pwrite &&
                   (csr_paddr[CSR_AW-1] == REG_CAPACITY);

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff <= CAP_RESET;
      end else if (reg_wr) begin
         cap_ff <= csr_pwdata[CAP_W-1:0];
      end
   end

   assign csr_prdata = (csr_paddr[CSR_AW-1] == REG_CAPACITY) ? CSR_DW'(cap_ff) : '0;

   // ---------------- assertions ----------------
   a_accept_report: assert property (@(posedge clock) disable iff (reset)
      acc |=> (state_ff == ST_REPORT))
      else $error("accepted command did not enter report cycle");

   a_report_strobe: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_REPORT) |=> rsp_strobe)
      else $error("report cycle not followed by status strobe");

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      EW'(fill_ff) <= DEPTH_E)
      else $error("fill count beyond depth");

   a_underflow_empty: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_underflow) |-> (!rsp_head_valid && (rsp_occupancy == '0)))
      else $error("underflow left entries in the queue");

   a_insert_nonempty: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_inserted) |-> rsp_head_valid)
      else $error("insert reported with empty queue");

endmodule
